/* sv/annexb_nal_unit_splitter_unit_assert.svh */
// Assertion macros shared by the start code splitter modules.
`ifndef ANNEXB_NAL_UNIT_SPLITTER_UNIT_ASSERT_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Checks a property on every clock edge outside reset.
`define ANB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that a condition in one cycle brings a result in the next.
`define ANB_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define ANB_ASSERT(lbl, clk, rst_n, prop, msg)
`define ANB_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

/* sv/anb_pkg.sv */
// Types, codes and helpers of the Annex B start code splitter.
`timescale 1ns / 1ps

package anb_pkg;

    // Default width of the internal unit length counter.
    localparam int LENGTH_BITS_DEF = 16;

    // Widths of the transaction fields.
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int STATUS_W = 2;

    // Most result items one stream byte can cause.
    localparam int MAX_ITEMS = 5;
    localparam int CNT_W     = 3;

    // Item kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    // End-of-unit status codes.
    localparam logic [STATUS_W-1:0] ST_START_CODE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CUT        = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_START   = 2'd2;

    // One result item.
    typedef struct packed {
        logic                kind;
        logic [BYTE_W-1:0]   data;
        logic [LEN_W-1:0]    length;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_item;

    // The items one stream byte causes, handed to the output buffer.
    typedef struct packed {
        logic [CNT_W-1:0]            cnt;
        t_item [MAX_ITEMS-1:0]       items;
    } t_batch;

    // Builds a payload item.
    function automatic t_item f_payload(input logic [BYTE_W-1:0] b);
        t_item it;
        it        = '0;
        it.kind   = KIND_PAYLOAD;
        it.data   = b;
        return it;
    endfunction

    // Builds an end-of-unit item.
    function automatic t_item f_end(input logic [LEN_W-1:0] len,
                                    input logic [STATUS_W-1:0] st);
        t_item it;
        it        = '0;
        it.kind   = KIND_END;
        it.length = len;
        it.status = st;
        return it;
    endfunction

endpackage

/* sv/anb_in_if.sv */
// Input channel: one stream byte per transaction.
`timescale 1ns / 1ps

interface anb_in_if;
    logic                          valid;
    logic                          ready;
    logic [anb_pkg::BYTE_W-1:0]    stream_byte;
    logic                          stream_end;

    modport source (output valid, output stream_byte, output stream_end, input ready);
    modport sink   (input valid, input stream_byte, input stream_end, output ready);
endinterface

/* sv/anb_out_if.sv */
// Output channel: one result item per transaction.
`timescale 1ns / 1ps

interface anb_out_if;
    logic                          valid;
    logic                          ready;
    logic                          item_kind;
    logic [anb_pkg::BYTE_W-1:0]    payload_byte;
    logic [anb_pkg::LEN_W-1:0]     unit_length;
    logic [anb_pkg::STATUS_W-1:0]  unit_status;
    logic                          last_of_step;

    modport source (output valid, output item_kind, output payload_byte,
                    output unit_length, output unit_status, output last_of_step,
                    input ready);
    modport sink   (input valid, input item_kind, input payload_byte,
                    input unit_length, input unit_status, input last_of_step,
                    output ready);
endinterface

/* sv/anb_core.sv */
// Input register, splitter state and the per-byte item builder.
`timescale 1ns / 1ps

module anb_core #(
    parameter int LENGTH_BITS = anb_pkg::LENGTH_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    anb_in_if.sink            i_in,
    input  logic              i_can_load,
    output logic              o_load,
    output anb_pkg::t_batch   o_batch
);

`include "annexb_nal_unit_splitter_unit_assert.svh"

    localparam logic [LENGTH_BITS-1:0] LenMax = '1;

    // Input register.
    logic                          r_in_valid;
    logic [anb_pkg::BYTE_W-1:0]    r_byte;
    logic                          r_end;

    // Splitter state.
    logic                          r_inside, n_inside;
    logic [anb_pkg::BYTE_W-1:0]    r_hb [3];
    logic [anb_pkg::BYTE_W-1:0]    n_hb [3];
    logic [1:0]                    r_hc, n_hc;
    logic [LENGTH_BITS-1:0]        r_len, n_len;

    logic                          w_tail;
    logic                          w_adv;
    anb_pkg::t_item                v_items [anb_pkg::MAX_ITEMS];
    logic [anb_pkg::CNT_W-1:0]     v_n;

    // Caps the counter to the width of the length field.
    function automatic logic [anb_pkg::LEN_W-1:0] f_cap(input logic [LENGTH_BITS-1:0] x);
        logic [31:0] w;
        w = 32'(x);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    assign w_adv      = r_in_valid && i_can_load;
    assign o_load     = w_adv;
    assign i_in.ready = !r_in_valid || i_can_load;

    // Input register takes a byte whenever the previous one moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_byte <= i_in.stream_byte;
            r_end  <= i_in.stream_end;
        end
    end

    // Two zeros at the tail of the lookahead.
    assign w_tail = (r_hc == 2'd2 && r_hb[0] == '0 && r_hb[1] == '0) ||
                    (r_hc == 2'd3 && r_hb[1] == '0 && r_hb[2] == '0);

    // Next state and the items this byte causes.
    always_comb begin
        n_inside = r_inside;
        n_hb     = r_hb;
        n_hc     = r_hc;
        n_len    = r_len;
        v_n      = '0;
        for (int k = 0; k < anb_pkg::MAX_ITEMS; k++) begin
            v_items[k] = '0;
        end

        if (!r_inside) begin
            // Searching for 00 00 01; held count tracks trailing zeros.
            if (r_byte == 8'h01 && r_hc >= 2'd2) begin
                n_inside = 1'b1;
                n_hc     = '0;
                n_hb     = '{default: '0};
                n_len    = '0;
            end else if (r_byte == '0) begin
                if (r_hc < 2'd2) begin
                    n_hc = r_hc + 2'd1;
                end
            end else begin
                n_hc = '0;
            end
        end else if (r_byte == 8'h01 && w_tail) begin
            // Start code ends the unit; a leading zero of a four-byte code is dropped.
            if (r_hc == 2'd3 && r_hb[0] != '0) begin
                v_items[v_n] = anb_pkg::f_payload(r_hb[0]);
                v_n          = v_n + 3'd1;
                if (n_len != LenMax) begin
                    n_len = n_len + 1'b1;
                end
            end
            v_items[v_n] = anb_pkg::f_end(f_cap(n_len), anb_pkg::ST_START_CODE);
            v_n          = v_n + 3'd1;
            n_hc         = '0;
            n_hb         = '{default: '0};
            n_len        = '0;
        end else if (r_hc != 2'd3) begin
            // Lookahead still filling.
            unique case (r_hc)
                2'd0:    n_hb[0] = r_byte;
                2'd1:    n_hb[1] = r_byte;
                default: n_hb[2] = r_byte;
            endcase
            n_hc = r_hc + 2'd1;
        end else begin
            // Oldest held byte leaves as payload.
            v_items[v_n] = anb_pkg::f_payload(r_hb[0]);
            v_n          = v_n + 3'd1;
            if (n_len != LenMax) begin
                n_len = n_len + 1'b1;
            end
            n_hb[0] = r_hb[1];
            n_hb[1] = r_hb[2];
            n_hb[2] = r_byte;
        end

        // Stream end flushes the lookahead and closes the unit, or reports that no start code was seen.
        if (r_end) begin
            if (n_inside) begin
                for (int k = 0; k < 3; k++) begin
                    if (k < int'(n_hc)) begin
                        v_items[v_n] = anb_pkg::f_payload(n_hb[k]);
                        v_n          = v_n + 3'd1;
                        if (n_len != LenMax) begin
                            n_len = n_len + 1'b1;
                        end
                    end
                end
                v_items[v_n] = anb_pkg::f_end(f_cap(n_len), anb_pkg::ST_CUT);
            end else begin
                v_items[v_n] = anb_pkg::f_end('0, anb_pkg::ST_NO_START);
            end
            v_n      = v_n + 3'd1;
            n_inside = 1'b0;
            n_hb     = '{default: '0};
            n_hc     = '0;
            n_len    = '0;
        end

        if (v_n != '0) begin
            v_items[v_n - 3'd1].last = 1'b1;
        end
    end

    // Batch handed to the output buffer.
    always_comb begin
        o_batch.cnt = v_n;
        for (int k = 0; k < anb_pkg::MAX_ITEMS; k++) begin
            o_batch.items[k] = v_items[k];
        end
    end

    // State advances with each byte that leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_hb     <= '{default: '0};
            r_hc     <= '0;
            r_len    <= '0;
        end else if (w_adv) begin
            r_inside <= n_inside;
            r_hb     <= n_hb;
            r_hc     <= n_hc;
            r_len    <= n_len;
        end
    end

    `ANB_ASSERT(a_search_count, i_clk, i_rst_n, (!r_inside) |-> (r_hc != 2'd3), "zero run count above two while searching")
    `ANB_ASSERT_NEXT(a_end_resets, i_clk, i_rst_n, (w_adv && r_end), (!r_inside && r_hc == 2'd0 && r_len == '0), "state not cleared after stream end")
    `ANB_ASSERT(a_end_has_item, i_clk, i_rst_n, (o_load && r_end) |-> (o_batch.cnt != '0), "stream end produced no end item")

endmodule

/* sv/anb_obuf.sv */
// Output result register that delivers a batch one item per transaction.
`timescale 1ns / 1ps

module anb_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  anb_pkg::t_batch   i_batch,
    output logic              o_can_load,
    anb_out_if.source         o_out
);

`include "annexb_nal_unit_splitter_unit_assert.svh"

    anb_pkg::t_item               r_items [anb_pkg::MAX_ITEMS];
    logic [anb_pkg::CNT_W-1:0]    r_cnt;
    logic                         w_pop;

    assign w_pop      = o_out.valid && o_out.ready;
    assign o_can_load = (r_cnt == '0) || (r_cnt == 3'd1 && o_out.ready);

    // Head of the queue drives the port.
    assign o_out.valid        = (r_cnt != '0);
    assign o_out.item_kind    = r_items[0].kind;
    assign o_out.payload_byte = r_items[0].data;
    assign o_out.unit_length  = r_items[0].length;
    assign o_out.unit_status  = r_items[0].status;
    assign o_out.last_of_step = r_items[0].last;

    // Item count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_batch.cnt;
        end else if (w_pop) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    // Item storage: load a batch or shift toward the head.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < anb_pkg::MAX_ITEMS; k++) begin
                r_items[k] <= i_batch.items[k];
            end
        end else if (w_pop) begin
            for (int k = 0; k < anb_pkg::MAX_ITEMS - 1; k++) begin
                r_items[k] <= r_items[k + 1];
            end
        end
    end

    `ANB_ASSERT(a_cnt_range, i_clk, i_rst_n, (r_cnt <= 3'd5), "item count above batch size")
    `ANB_ASSERT(a_last_flag, i_clk, i_rst_n, (r_cnt != '0) |-> (o_out.last_of_step == (r_cnt == 3'd1)), "last flag not on final item")
    `ANB_ASSERT_NEXT(a_drain, i_clk, i_rst_n, (w_pop && !i_load), (r_cnt == $past(r_cnt) - 3'd1), "count did not drop after a transaction")

endmodule

/* sv/annexb_nal_unit_splitter_unit.sv */
// Top level of the H.264 Annex B start code splitter.
`timescale 1ns / 1ps

// Takes one Annex B byte per transaction and returns the payload bytes of each
// unit, each followed by an end item with the unit length (capped at 65535)
// and a status: ended by a start code, cut by stream end, or no start code
// seen. A byte moves from the input register into the output register. The
// block takes one byte per cycle while each byte causes at most one result
// item and the output takes each item when offered; a byte that causes
// several items (up to five at stream end) holds the single output port
// until all are taken, and the next byte waits in the input register
// meanwhile. Bytes that cause no item pass at one per cycle.
module annexb_nal_unit_splitter_unit #(
    parameter int LENGTH_BITS = anb_pkg::LENGTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    anb_in_if.sink     i_in,
    anb_out_if.source  o_out
);

    logic              w_can_load;
    logic              w_load;
    anb_pkg::t_batch   w_batch;

    // Byte processing and splitter state.
    anb_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_can_load (w_can_load),
        .o_load     (w_load),
        .o_batch    (w_batch)
    );

    // Result delivery.
    anb_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_batch    (w_batch),
        .o_can_load (w_can_load),
        .o_out      (o_out)
    );

endmodule
